// ===== rtl/lsfp_pkg.sv =====
// lsfp_pkg: shared types and constants for the lidar scan frame parser
// no dependencies; imported by every module of the block

package lsfp_pkg;

	localparam logic [14:0] FULL_TURN_Q6   = 15'd23040;
	localparam logic [15:0] MIN_DIST_RESET = 16'd800;
	localparam logic [15:0] MAX_DIST_RESET = 16'd2000;

	localparam logic [1:0] SYNC_MASK = 2'b11;
	localparam logic [1:0] SYNC_CODE = 2'b01;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam int PADDR_W = 3;

	localparam logic REG_MIN_DISTANCE = 1'b0;
	localparam logic REG_MAX_DISTANCE = 1'b1;

	typedef struct packed {
		logic [14:0] angle_raw;
		logic [15:0] distance;
		logic [5:0]  quality;
	} frame_t;

	typedef struct packed {
		logic [15:0] min_distance;
		logic [15:0] max_distance;
	} window_t;

	typedef enum logic [4:0] {
		ST_HUNT = 5'b00001,
		ST_B1   = 5'b00010,
		ST_B2   = 5'b00100,
		ST_B3   = 5'b01000,
		ST_B4   = 5'b10000
	} frame_state_t;

endpackage

// ===== rtl/lidar_scan_frame_parser.sv =====
// lidar_scan_frame_parser: top level, config registers and part wiring
// depends on lsfp_pkg, lsfp_front, lsfp_queue, lsfp_back

// One received byte is taken per clock while full is low. A frame starts on a
// byte whose low two bits are 01 with nonzero quality bits; four more bytes
// complete it, and the sample leaves only if its distance lies in
// [min_distance, max_distance] (registers at 0x0 and 0x4, reset 800 and
// 2000). Completed frames wait in a two-entry queue before the window check,
// so full rises only when both entries and the result register are held.

module lidar_scan_frame_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lsfp_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    rx_byte,
	output logic                          empty,
	input  logic                          pop,
	output logic [14:0]                   angle_q6,
	output logic [15:0]                   distance_q2,
	output logic [5:0]                    quality
);
	import lsfp_pkg::*;

	window_t window_q;
	logic    cfg_wr;
	logic    reg_idx;
	logic    byte_valid;
	logic    frame_push;
	frame_t  frame_data;
	logic    q_pop;
	frame_t  q_data;
	logic    q_full;
	logic    q_empty;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q.min_distance <= MIN_DIST_RESET;
			window_q.max_distance <= MAX_DIST_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MIN_DISTANCE: window_q.min_distance <= pwdata[15:0];
				REG_MAX_DISTANCE: window_q.max_distance <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MIN_DISTANCE: prdata = {16'd0, window_q.min_distance};
			REG_MAX_DISTANCE: prdata = {16'd0, window_q.max_distance};
			default:          prdata = '0;
		endcase
	end

	assign full       = q_full;
	assign byte_valid = push && !full;

	lsfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.rx_byte    (rx_byte),
		.frame_push (frame_push),
		.frame_data (frame_data)
	);

	lsfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (frame_push),
		.push_data (frame_data),
		.pop       (q_pop),
		.pop_data  (q_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	lsfp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.window      (window_q),
		.q_empty     (q_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.angle_q6    (angle_q6),
		.distance_q2 (distance_q2),
		.quality     (quality)
	);

endmodule

// ===== rtl/lsfp_front.sv =====
// lsfp_front: hunts for the sync byte and gathers five-byte frames
// depends on lsfp_pkg; hands complete raw frames to lsfp_queue

module lsfp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	input  logic [7:0]      rx_byte,
	output logic            frame_push,
	output lsfp_pkg::frame_t frame_data
);
	import lsfp_pkg::*;

	frame_state_t state_q;
	logic [5:0]   quality_q;
	logic [7:0]   b1_q;
	logic [7:0]   b2_q;
	logic [7:0]   b3_q;
	logic         sync_hit;

	assign sync_hit = ((rx_byte[1:0] & SYNC_MASK) == SYNC_CODE) && (rx_byte[7:2] != 6'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else if (byte_valid) begin
			unique case (state_q)
				ST_HUNT: begin
					if (sync_hit) begin
						state_q <= ST_B1;
					end
				end
				ST_B1:   state_q <= ST_B2;
				ST_B2:   state_q <= ST_B3;
				ST_B3:   state_q <= ST_B4;
				ST_B4:   state_q <= ST_HUNT;
				default: state_q <= ST_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid) begin
			if (state_q == ST_HUNT && sync_hit) begin
				quality_q <= rx_byte[7:2];
			end
			if (state_q == ST_B1) begin
				b1_q <= rx_byte;
			end
			if (state_q == ST_B2) begin
				b2_q <= rx_byte;
			end
			if (state_q == ST_B3) begin
				b3_q <= rx_byte;
			end
		end
	end

	// last byte completes the frame
	assign frame_push            = byte_valid && (state_q == ST_B4);
	assign frame_data.angle_raw  = {b2_q, b1_q[7:1]};
	assign frame_data.distance   = {rx_byte, b3_q};
	assign frame_data.quality    = quality_q;

`ifndef SYNTH
	a_push_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		frame_push |=> state_q == ST_HUNT)
		else $error("frame push did not return to hunting");
	a_push_after_four: assert property (@(posedge clk) disable iff (!arst_n)
		frame_push |-> $past(state_q) == ST_B3 || $past(state_q) == ST_B4)
		else $error("frame push without preceding bytes");
	a_quality_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		frame_push |-> quality_q != 6'd0)
		else $error("frame pushed with zero quality");
`endif

endmodule

// ===== rtl/lsfp_queue.sv =====
// lsfp_queue: short queue of raw frames between framing and filtering
// depends on lsfp_pkg for the frame type and depth

module lsfp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lsfp_pkg::frame_t push_data,
	input  logic             pop,
	output lsfp_pkg::frame_t pop_data,
	output logic             full,
	output logic             empty
);
	import lsfp_pkg::*;

	frame_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count overflow");
	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !do_push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not drop on pop");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == count_q[QPTR_W-1:0])
		else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/lsfp_back.sv =====
// lsfp_back: wraps the angle, applies the distance window, holds the result
// depends on lsfp_pkg; drains lsfp_queue

module lsfp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  lsfp_pkg::window_t window,
	input  logic              q_empty,
	input  lsfp_pkg::frame_t  q_data,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output logic [14:0]       angle_q6,
	output logic [15:0]       distance_q2,
	output logic [5:0]        quality
);
	import lsfp_pkg::*;

	logic        out_valid_q;
	logic [14:0] angle_q;
	logic [15:0] dist_q;
	logic [5:0]  qual_q;
	logic [14:0] angle_wrap;
	logic        in_window;

	assign angle_wrap = (q_data.angle_raw >= FULL_TURN_Q6) ?
		q_data.angle_raw - FULL_TURN_Q6 : q_data.angle_raw;
	assign in_window  = (q_data.distance >= window.min_distance) &&
		(q_data.distance <= window.max_distance);

	assign q_pop = !q_empty && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= in_window;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && in_window) begin
			angle_q <= angle_wrap;
			dist_q  <= q_data.distance;
			qual_q  <= q_data.quality;
		end
	end

	assign empty       = !out_valid_q;
	assign angle_q6    = angle_q;
	assign distance_q2 = dist_q;
	assign quality     = qual_q;

`ifndef SYNTH
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> angle_q < FULL_TURN_Q6)
		else $error("angle out of range");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(dist_q))
		else $error("pending result lost");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !out_valid_q || pop)
		else $error("queue drained over pending result");
`endif

endmodule
